### hdl/blur_pkg.sv
package blur_pkg;

    // Register file layout
    localparam int WIDTH_CFG_W   = 12;
    localparam int HEIGHT_CFG_W  = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 16'd480;

    // Defaults for top-level parameters
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int ACC_W  = CHAN_W + 4;

    // Red sits in the low byte, matching the stream packing
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pix;

    // Which results a beat causes, and how its window edges clamp
    typedef struct packed {
        logic [3:0] mask;    // bit0 (r-1,c-1), bit1 (r-1,W-1), bit2 (r,c-1), bit3 (r,W-1)
        logic       r_ge2;
        logic       r_ge1;
        logic       c_ge2;
        logic       c_ge1;
    } t_sel;

    // Window: index row*3+col, row 0 oldest line, col 2 newest column
    typedef struct packed {
        t_pix [8:0] win;
        t_sel       sel;
    } t_job;

    typedef struct packed {
        logic full;
        logic afull;
    } t_q_stat;

endpackage

### hdl/blur_front.sv
module blur_front #(
    parameter int MAX_WIDTH = blur_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [blur_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [blur_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    input  blur_pkg::t_pix                    i_pix,
    output logic                              o_ready,
    input  blur_pkg::t_q_stat                 i_q_stat,
    output logic                              o_push,
    output blur_pkg::t_job                    o_job
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 1 > blur_pkg::WIDTH_CFG_W) ? AW + 1 : blur_pkg::WIDTH_CFG_W;
    localparam int HW = blur_pkg::HEIGHT_CFG_W;
    localparam int LW = 2 * blur_pkg::PIX_W;

    logic [blur_pkg::WIDTH_CFG_W-1:0] r_cfg_w;
    logic [HW-1:0]                    r_cfg_h;

    logic [AW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;

    logic [CW-1:0] w_eff, w_m1, c_ext, c_cl;
    logic [HW-1:0] h_eff, h_m1, r_cl;
    logic [AW-1:0] c_idx;
    logic          last_c, last_r, accept;
    blur_pkg::t_sel sel;

    // Stage 1: line store data is back
    logic              r_s1_valid;
    blur_pkg::t_pix    r_s1_pix;
    logic [AW-1:0]     r_s1_col;
    logic              r_s1_fwd;
    blur_pkg::t_sel    r_s1_sel;

    logic [LW-1:0]     r_line [MAX_WIDTH];
    logic [LW-1:0]     r_rd;
    logic [LW-1:0]     r_fw;
    logic [LW-1:0]     line_eff;

    blur_pkg::t_pix [8:0] r_win, n_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= blur_pkg::WIDTH_RST;
            r_cfg_h <= blur_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                blur_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data[blur_pkg::WIDTH_CFG_W-1:0];
                blur_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size and position
    always_comb begin
        w_eff = CW'(r_cfg_w);
        if (r_cfg_w == '0) begin
            w_eff = CW'(1);
        end else if (CW'(r_cfg_w) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end
        w_m1  = w_eff - CW'(1);
        c_ext = CW'(r_col);
        c_cl  = (c_ext >= w_eff) ? w_m1 : c_ext;
        c_idx = c_cl[AW-1:0];

        h_eff = (r_cfg_h == '0) ? HW'(1) : r_cfg_h;
        h_m1  = h_eff - HW'(1);
        r_cl  = (r_row >= h_eff) ? h_m1 : r_row;

        last_c = (c_cl == w_m1);
        last_r = (r_cl == h_m1);

        sel.r_ge1 = (r_cl != '0);
        sel.r_ge2 = (r_cl[HW-1:1] != '0);
        sel.c_ge1 = (c_idx != '0);
        sel.c_ge2 = (c_cl[CW-1:1] != '0);
        sel.mask  = {last_r & last_c, last_r & sel.c_ge1,
                     sel.r_ge1 & last_c, sel.r_ge1 & sel.c_ge1};

        if (last_c) begin
            n_col = '0;
            n_row = last_r ? '0 : r_cl + HW'(1);
        end else begin
            n_col = c_idx + AW'(1);
            n_row = r_cl;
        end
    end

    // Leave room for the beat in stage 1 as well as this one
    assign o_ready = r_s1_valid ? !i_q_stat.afull : !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_pix;
            r_s1_col <= c_idx;
            r_s1_sel <= sel;
            // Previous beat writes the same entry this cycle: take its data
            r_s1_fwd <= r_s1_valid && (r_s1_col == c_idx);
        end
    end

    // Line store: upper row in the high half, middle row in the low half
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[c_idx];
        end
    end

    assign line_eff = r_s1_fwd ? r_fw : r_rd;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line[r_s1_col] <= {line_eff[blur_pkg::PIX_W-1:0], r_s1_pix};
            r_fw             <= {line_eff[blur_pkg::PIX_W-1:0], r_s1_pix};
        end
    end

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = line_eff[LW-1:blur_pkg::PIX_W];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = line_eff[blur_pkg::PIX_W-1:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Drop beats that cause no result
    assign o_push    = r_s1_valid && (r_s1_sel.mask != '0);
    assign o_job.win = n_win;
    assign o_job.sel = r_s1_sel;

endmodule

### hdl/blur_queue.sv
module blur_queue #(
    parameter int DEPTH = blur_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  blur_pkg::t_job     i_job,
    input  logic               i_pop,
    output logic               o_valid,
    output blur_pkg::t_job     o_job,
    output blur_pkg::t_q_stat  o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    blur_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [NW-1:0]  r_cnt;
    logic           do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    assign o_valid      = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt >= NW'(DEPTH));
    assign o_stat.afull = (r_cnt >= NW'(DEPTH - 1));

endmodule

### hdl/blur_back.sv
module blur_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  blur_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output blur_pkg::t_pix       o_tdata,
    output logic                 o_tlast,
    output logic                 o_tuser
);

    localparam int CW = blur_pkg::CHAN_W;
    localparam int AC = blur_pkg::ACC_W;

    logic            r_busy;
    blur_pkg::t_job  r_job;
    logic [3:0]      r_left;

    logic            r_ovalid;
    blur_pkg::t_pix  r_odata;
    logic            r_olast, r_ouser;

    logic            can_load, fire, last, take;
    logic [3:0]      cur;
    logic            use_prev_r, use_prev_c;
    logic [1:0]      rs [3];
    logic [1:0]      cs [3];
    blur_pkg::t_pix  ctr;
    blur_pkg::t_pix  nb [8];
    blur_pkg::t_pix  res;
    logic [AC-1:0]   acc_r, acc_g, acc_b;

    function automatic blur_pkg::t_pix pick(blur_pkg::t_pix [8:0] win,
                                            logic [1:0] row, logic [1:0] col);
        logic [3:0] idx;
        idx = 4'(row) * 4'd3 + 4'(col);
        return win[idx];
    endfunction

    assign can_load = !r_ovalid || i_tready;
    assign fire     = r_busy && can_load;
    assign cur      = r_left & (~r_left + 4'd1);
    assign last     = ((r_left & ~cur) == '0);
    assign take     = (!r_busy || (fire && last)) && i_valid;
    assign o_pop    = take;

    // Row and column choice, with edge clamping
    always_comb begin
        use_prev_r = cur[0] | cur[1];
        use_prev_c = cur[0] | cur[2];
        if (use_prev_r) begin
            rs[0] = r_job.sel.r_ge2 ? 2'd0 : 2'd1;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
        end else begin
            rs[0] = r_job.sel.r_ge1 ? 2'd1 : 2'd2;
            rs[1] = 2'd2;
            rs[2] = 2'd2;
        end
        if (use_prev_c) begin
            cs[0] = r_job.sel.c_ge2 ? 2'd0 : 2'd1;
            cs[1] = 2'd1;
            cs[2] = 2'd2;
        end else begin
            cs[0] = r_job.sel.c_ge1 ? 2'd1 : 2'd2;
            cs[1] = 2'd2;
            cs[2] = 2'd2;
        end
    end

    always_comb begin
        int k;
        ctr   = pick(r_job.win, rs[1], cs[1]);
        nb[0] = pick(r_job.win, rs[0], cs[0]);
        nb[1] = pick(r_job.win, rs[0], cs[1]);
        nb[2] = pick(r_job.win, rs[0], cs[2]);
        nb[3] = pick(r_job.win, rs[1], cs[0]);
        nb[4] = pick(r_job.win, rs[1], cs[2]);
        nb[5] = pick(r_job.win, rs[2], cs[0]);
        nb[6] = pick(r_job.win, rs[2], cs[1]);
        nb[7] = pick(r_job.win, rs[2], cs[2]);
        // Center weighs eight, each neighbor one
        acc_r = {1'b0, ctr.red,   3'b000};
        acc_g = {1'b0, ctr.green, 3'b000};
        acc_b = {1'b0, ctr.blue,  3'b000};
        for (k = 0; k < 8; k++) begin
            acc_r = acc_r + AC'(nb[k].red);
            acc_g = acc_g + AC'(nb[k].green);
            acc_b = acc_b + AC'(nb[k].blue);
        end
        res.red   = acc_r[AC-1:AC-CW];
        res.green = acc_g[AC-1:AC-CW];
        res.blue  = acc_b[AC-1:AC-CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (fire && last) begin
                r_busy <= 1'b0;
            end
            if (can_load) begin
                r_ovalid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job  <= i_job;
            r_left <= i_job.sel.mask;
        end else if (fire) begin
            r_left <= r_left & ~cur;
        end
        if (fire) begin
            r_odata <= res;
            r_olast <= last;
            r_ouser <= cur[3];
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_ouser;

endmodule

### hdl/blur_3x3_center_weighted_stream_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[23:0] = red, green, blue (low bits up)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[23:0] = red, green, blue; tlast; tuser
// cfg       in   i_cfg_we (no wait)           i_cfg_addr: 0 width, 1 height; i_cfg_data
//
// Beats are taken back to back while each causes at most one result; the filter and the
// output register move one result a cycle unless the output stalls, so a beat with two
// results (last column, or last row of a frame taller than one row) and the last beat of
// a frame, with up to four results, hold the filter for one result after another. Along
// the last row the input is held back by the filter once the queue fills.
// The first result of a beat passes the line store read, the queue, the filter's job
// register and the output register before it shows.
// Reset clears counters, window, queue and output; size returns to 640 x 480. The line
// store is not cleared: rows above the frame are never read into a result.
// The job queue between classifier and filter lets the output stall without
// stopping input until the queue fills.
module blur_3x3_center_weighted_stream_top #(
    parameter int MAX_WIDTH   = blur_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = blur_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [blur_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [blur_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [blur_pkg::PIX_W-1:0]       s_axis_tdata,  // red_in, green_in, blue_in
    // blurred pixel out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [blur_pkg::PIX_W-1:0]       m_axis_tdata,  // red_out, green_out, blue_out
    output logic                             m_axis_tlast,  // run_last
    output logic                             m_axis_tuser   // frame_end
);

    logic               push, pop, q_valid;
    blur_pkg::t_job     push_job, q_job;
    blur_pkg::t_q_stat  q_stat;
    blur_pkg::t_pix     out_pix;

    // Front: counters, line store, window, classify each beat
    blur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_pix      (blur_pkg::t_pix'(s_axis_tdata)),
        .o_ready    (s_axis_tready),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Hold window snapshots until the filter gets to them
    blur_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    // Back: one filtered pixel per cycle into the output register while the output does not stall
    blur_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (out_pix),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

    assign m_axis_tdata = out_pix;

endmodule
